// ===== design/lcdns_pkg.sv =====
// Shared types, constants and the nibble step decoder for the character LCD sequencer.
`timescale 1ns / 1ps

package lcdns_pkg;

    // Request codes as they arrive in the mode field.
    localparam logic [2:0] MODE_INIT       = 3'd0;
    localparam logic [2:0] MODE_CLEAR      = 3'd1;
    localparam logic [2:0] MODE_CHAR       = 3'd2;
    localparam logic [2:0] MODE_STR_BEGIN  = 3'd3;
    localparam logic [2:0] MODE_STR_CHAR   = 3'd4;
    localparam logic [2:0] MODE_STR_END    = 3'd5;

    // Configuration register indexes and reset values.
    localparam int          CFG_INDEX_W      = 2;
    localparam int          CFG_DATA_W       = 16;
    localparam logic [1:0]  CFG_SHORT_WAIT   = 2'd0;
    localparam logic [1:0]  CFG_CLEAR_WAIT   = 2'd1;
    localparam logic [1:0]  CFG_POWER_UP     = 2'd2;
    localparam logic [7:0]  SHORT_WAIT_RST   = 8'd3;
    localparam logic [13:0] CLEAR_WAIT_RST   = 14'd2000;
    localparam logic [15:0] POWER_UP_RST     = 16'd15000;

    // Fixed waits of the wake-up sequence.
    localparam logic [15:0] INIT_WAIT2_US    = 16'd5000;
    localparam logic [15:0] INIT_WAIT3_US    = 16'd2000;

    // Display command bytes and raw wake-up nibbles.
    localparam logic [7:0]  CMD_CLEAR        = 8'h01;
    localparam logic [7:0]  CMD_FUNC_SET     = 8'h28;
    localparam logic [7:0]  CMD_DISPLAY_OFF  = 8'h08;
    localparam logic [7:0]  CMD_ENTRY_MODE   = 8'h06;
    localparam logic [7:0]  CMD_DISPLAY_ON   = 8'h0C;
    localparam logic [7:0]  CMD_SET_ADDR     = 8'h80;
    localparam logic [3:0]  WAKE_NIBBLE      = 4'h3;
    localparam logic [3:0]  FOUR_BIT_NIBBLE  = 4'h2;

    // Nibble counts per request.
    localparam int INIT_RAW_NIBBLES = 3;
    localparam int INIT_LEN         = 15;
    localparam int CLEAR_LEN        = 4;
    localparam int CHAR_LEN         = 6;
    localparam int STR_BEGIN_LEN    = 6;
    localparam int STR_CHAR_LEN     = 2;
    localparam int STR_END_LEN      = 2;
    localparam int MAX_LEN          = INIT_LEN;
    localparam int STEP_W           = $clog2(MAX_LEN);

    localparam int QUEUE_DEPTH      = 2;

    typedef enum logic [2:0] {
        REQ_INIT,
        REQ_CLEAR,
        REQ_CHAR,
        REQ_STR_BEGIN,
        REQ_STR_CHAR,
        REQ_STR_END
    } t_req_kind;

    typedef enum logic [2:0] {
        SETTLE_SHORT,
        SETTLE_AFTER_CLEAR,
        SETTLE_POWER_UP,
        SETTLE_INIT_5MS,
        SETTLE_INIT_2MS
    } t_settle_sel;

    typedef struct packed {
        t_req_kind  kind;
        logic [7:0] char_code;
        logic [6:0] address;
    } t_entry;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_push;

    typedef struct packed {
        logic [7:0]  short_wait_us;
        logic [13:0] clear_wait_us;
        logic [15:0] power_up_wait_us;
    } t_cfg;

    typedef struct packed {
        logic [3:0]  nibble;
        logic        reg_select;
        t_settle_sel settle;
        logic        last;
    } t_nib;

    typedef struct packed {
        logic              mid_request;
        logic [STEP_W-1:0] step;
    } t_back_status;

    // Works out one nibble of a request from its position in the sequence.
    function automatic t_nib step_decode(t_entry e, logic [STEP_W-1:0] step);
        t_nib              r;
        logic [7:0]        b;
        logic              hi;
        logic [STEP_W-1:0] bs;
        logic [2:0]        bi;
        t_settle_sel       fs;
        logic              rs;
        logic [STEP_W-1:0] final_step;
        b          = CMD_SET_ADDR;
        fs         = SETTLE_SHORT;
        rs         = 1'b0;
        final_step = STEP_W'(STR_END_LEN - 1);
        if (e.kind == REQ_INIT) begin
            bs = step - STEP_W'(INIT_RAW_NIBBLES);
        end else begin
            bs = step;
        end
        bi = 3'(bs >> 1);
        hi = !bs[0];
        unique case (e.kind)
            REQ_INIT: begin
                final_step = STEP_W'(INIT_LEN - 1);
                case (bi)
                    3'd0: begin
                        b  = CMD_CLEAR;
                        fs = SETTLE_INIT_2MS;
                    end
                    3'd1: begin
                        b  = CMD_FUNC_SET;
                        fs = SETTLE_AFTER_CLEAR;
                    end
                    3'd2: b = CMD_DISPLAY_OFF;
                    3'd3: b = CMD_ENTRY_MODE;
                    3'd4: b = CMD_CLEAR;
                    default: begin
                        b  = CMD_DISPLAY_ON;
                        fs = SETTLE_AFTER_CLEAR;
                    end
                endcase
            end
            REQ_CLEAR: begin
                final_step = STEP_W'(CLEAR_LEN - 1);
                if (bi == 3'd0) begin
                    b = CMD_CLEAR;
                end else begin
                    b  = CMD_DISPLAY_ON;
                    fs = SETTLE_AFTER_CLEAR;
                end
            end
            REQ_CHAR: begin
                final_step = STEP_W'(CHAR_LEN - 1);
                case (bi)
                    3'd0: b = CMD_SET_ADDR | {1'b0, e.address};
                    3'd1: begin
                        b  = e.char_code;
                        rs = 1'b1;
                    end
                    default: b = CMD_SET_ADDR;
                endcase
            end
            REQ_STR_BEGIN: begin
                final_step = STEP_W'(STR_BEGIN_LEN - 1);
                case (bi)
                    3'd0:    b = CMD_FUNC_SET;
                    3'd1:    b = CMD_SET_ADDR | {1'b0, e.address};
                    default: b = CMD_DISPLAY_ON;
                endcase
            end
            REQ_STR_CHAR: begin
                final_step = STEP_W'(STR_CHAR_LEN - 1);
                b          = e.char_code;
                rs         = 1'b1;
            end
            default: begin
                final_step = STEP_W'(STR_END_LEN - 1);
                b          = CMD_SET_ADDR;
            end
        endcase
        r.nibble     = hi ? b[7:4] : b[3:0];
        r.settle     = hi ? fs : SETTLE_SHORT;
        r.reg_select = rs;
        // The wake-up nibbles at the head of init are not halves of a byte.
        if ((e.kind == REQ_INIT) && (step < STEP_W'(INIT_RAW_NIBBLES))) begin
            r.reg_select = 1'b0;
            if (step == STEP_W'(0)) begin
                r.nibble = WAKE_NIBBLE;
                r.settle = SETTLE_POWER_UP;
            end else if (step == STEP_W'(1)) begin
                r.nibble = WAKE_NIBBLE;
                r.settle = SETTLE_INIT_5MS;
            end else begin
                r.nibble = FOUR_BIT_NIBBLE;
                r.settle = SETTLE_INIT_2MS;
            end
        end
        r.last = (step == final_step);
        return r;
    endfunction

endpackage

// ===== design/lcdns_front.sv =====
// Input side: takes request transfers, classifies the mode and drops unknown codes.
`timescale 1ns / 1ps

module lcdns_front (
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [2:0]          i_mode,
    input  logic [7:0]          i_char_code,
    input  logic [6:0]          i_address,
    input  logic                i_queue_full,
    output lcdns_pkg::t_push    o_push
);

    logic                 known;
    lcdns_pkg::t_req_kind kind;

    always_comb begin
        known = 1'b1;
        kind  = lcdns_pkg::REQ_STR_END;
        unique case (i_mode)
            lcdns_pkg::MODE_INIT:      kind = lcdns_pkg::REQ_INIT;
            lcdns_pkg::MODE_CLEAR:     kind = lcdns_pkg::REQ_CLEAR;
            lcdns_pkg::MODE_CHAR:      kind = lcdns_pkg::REQ_CHAR;
            lcdns_pkg::MODE_STR_BEGIN: kind = lcdns_pkg::REQ_STR_BEGIN;
            lcdns_pkg::MODE_STR_CHAR:  kind = lcdns_pkg::REQ_STR_CHAR;
            lcdns_pkg::MODE_STR_END:   kind = lcdns_pkg::REQ_STR_END;
            default:                   known = 1'b0;
        endcase
    end

    // Unknown codes are still taken, they simply never reach the queue.
    assign s_axis_tready             = !i_queue_full;
    assign o_push.valid              = s_axis_tvalid && !i_queue_full && known;
    assign o_push.entry.kind         = kind;
    assign o_push.entry.char_code    = i_char_code;
    assign o_push.entry.address      = i_address;

endmodule

// ===== design/lcdns_queue.sv =====
// Small request queue between the front and back sides.
`timescale 1ns / 1ps

module lcdns_queue #(
    parameter int DEPTH = lcdns_pkg::QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lcdns_pkg::t_push    i_push,
    input  logic                i_pop,
    output logic                o_full,
    output logic                o_empty,
    output lcdns_pkg::t_entry   o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    lcdns_pkg::t_entry r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push.valid) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push.valid && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push.valid && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.entry;
        end
    end

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

endmodule

// ===== design/lcdns_back.sv =====
// Output side: steps through the nibbles of the head request into an output register.
`timescale 1ns / 1ps

module lcdns_back (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  lcdns_pkg::t_cfg          i_cfg,
    input  logic                     i_head_valid,
    input  lcdns_pkg::t_entry        i_head,
    output logic                     o_pop,
    output lcdns_pkg::t_back_status  o_status,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [3:0]               o_nibble,
    output logic                     o_reg_select,
    output logic [15:0]              o_settle_us,
    output logic                     o_last
);

    logic [lcdns_pkg::STEP_W-1:0] r_step, n_step;
    logic                         r_out_valid, n_out_valid;
    logic                         advance;
    lcdns_pkg::t_nib              nib;
    logic [15:0]                  settle;
    logic [3:0]                   r_nibble;
    logic                         r_reg_select;
    logic [15:0]                  r_settle_us;
    logic                         r_last;

    assign nib     = lcdns_pkg::step_decode(i_head, r_step);
    assign advance = i_head_valid && (!r_out_valid || m_axis_tready);
    assign o_pop   = advance && nib.last;

    always_comb begin
        unique case (nib.settle)
            lcdns_pkg::SETTLE_SHORT:       settle = {8'd0, i_cfg.short_wait_us};
            lcdns_pkg::SETTLE_AFTER_CLEAR: settle = {8'd0, i_cfg.short_wait_us}
                                                  + {2'd0, i_cfg.clear_wait_us};
            lcdns_pkg::SETTLE_POWER_UP:    settle = i_cfg.power_up_wait_us;
            lcdns_pkg::SETTLE_INIT_5MS:    settle = lcdns_pkg::INIT_WAIT2_US;
            lcdns_pkg::SETTLE_INIT_2MS:    settle = lcdns_pkg::INIT_WAIT3_US;
            default:                       settle = {8'd0, i_cfg.short_wait_us};
        endcase
    end

    always_comb begin
        n_step      = r_step;
        n_out_valid = r_out_valid;
        if (advance) begin
            n_step      = nib.last ? '0 : r_step + 1'b1;
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_nibble     <= nib.nibble;
            r_reg_select <= nib.reg_select;
            r_settle_us  <= settle;
            r_last       <= nib.last;
        end
    end

    assign o_status.mid_request = (r_step != '0);
    assign o_status.step        = r_step;
    assign m_axis_tvalid        = r_out_valid;
    assign o_nibble             = r_nibble;
    assign o_reg_select         = r_reg_select;
    assign o_settle_us          = r_settle_us;
    assign o_last               = r_last;

endmodule

// ===== design/char_lcd_nibble_sequencer.sv =====
// Top level of the character LCD four-bit nibble sequencer.
`timescale 1ns / 1ps

// Channel    Direction  Transfer moves
// s_axis     in         one display request: mode, character byte, address
// m_axis     out        one nibble write: nibble, settle time, register select, last flag
// i_cfg_*    in         one register write: short, clear and power-up waits
//
// Each request becomes 2 to 15 nibble transfers on m_axis, one per cycle while the
// output is taken; init gives 15, clear 4, character and string begin 6, the others 2.
// That figure is set by the back sequencer, which issues one nibble of the head request
// per cycle while the output is taken. Unknown modes are taken and give no transfer.
// A two-entry request queue sits between the front and back, so new requests are
// accepted while a nibble waits in the output register; s_axis_tready falls only when
// the queue is full. Reset is synchronous and active low; it empties the queue, clears
// the output register's valid flag and loads the register reset values.

module char_lcd_nibble_sequencer #(
    parameter int QUEUE_DEPTH = lcdns_pkg::QUEUE_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write port
    input  logic                              i_cfg_we,
    input  logic [lcdns_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [lcdns_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    // Request stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [23:0]                       s_axis_tdata,  // mode[2:0], char_code[10:3],
                                                             // address[17:11], zero fill
    // Nibble stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [23:0]                       m_axis_tdata,  // nibble[3:0], settle_us[19:4],
                                                             // zero fill
    output logic                              m_axis_tuser,  // reg_select
    output logic                              m_axis_tlast   // last
);

    lcdns_pkg::t_cfg          r_cfg;
    lcdns_pkg::t_push         push;
    lcdns_pkg::t_entry        head;
    lcdns_pkg::t_back_status  back_status;
    logic                     queue_full;
    logic                     queue_empty;
    logic                     pop;
    logic [3:0]               nibble;
    logic [15:0]              settle_us;

    // Configuration registers. Writes come only while the block is idle, so the back side
    // reads them directly; the user is bound to this, the block itself does not enforce it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.short_wait_us    <= lcdns_pkg::SHORT_WAIT_RST;
            r_cfg.clear_wait_us    <= lcdns_pkg::CLEAR_WAIT_RST;
            r_cfg.power_up_wait_us <= lcdns_pkg::POWER_UP_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                lcdns_pkg::CFG_SHORT_WAIT: r_cfg.short_wait_us    <= i_cfg_wdata[7:0];
                lcdns_pkg::CFG_CLEAR_WAIT: r_cfg.clear_wait_us    <= i_cfg_wdata[13:0];
                lcdns_pkg::CFG_POWER_UP:   r_cfg.power_up_wait_us <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    lcdns_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .i_mode        (s_axis_tdata[2:0]),
        .i_char_code   (s_axis_tdata[10:3]),
        .i_address     (s_axis_tdata[17:11]),
        .i_queue_full  (queue_full),
        .o_push        (push)
    );

    lcdns_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_full  (queue_full),
        .o_empty (queue_empty),
        .o_head  (head)
    );

    lcdns_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_head_valid  (!queue_empty),
        .i_head        (head),
        .o_pop         (pop),
        .o_status      (back_status),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .o_nibble      (nibble),
        .o_reg_select  (m_axis_tuser),
        .o_settle_us   (settle_us),
        .o_last        (m_axis_tlast)
    );

    assign m_axis_tdata = {4'd0, settle_us, nibble};

    // The sequencer is only part-way through a request while that request heads the queue.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_status.mid_request |-> !queue_empty)
        else $error("back side mid-request with an empty queue");

    // The queue can never report full and empty together.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(queue_full && queue_empty))
        else $error("queue reports full and empty at once");

    // A request that enters the queue is there on the next cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.valid |=> !queue_empty)
        else $error("pushed request missing from the queue");

    // A pop happens only on the final nibble, after which the step count restarts.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |=> !back_status.mid_request)
        else $error("step count not restarted after the final nibble");

    // The step count never runs past the longest request.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(back_status.step) < lcdns_pkg::MAX_LEN)
        else $error("step count beyond the longest request");

endmodule
